@@ rtl/tbpd_pkg.sv @@
// Shared types and constants for the tilt balance PD controller.
// No dependencies; imported by every module of the block.
package tbpd_pkg;

  typedef enum logic [1:0] {
    ACT_DRIVE = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_LOCK  = 2'd2
  } action_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_GAIN_P    = 2'd0;
  localparam logic [1:0] REG_GAIN_D    = 2'd1;
  localparam logic [1:0] REG_SPEED_CAP = 2'd2;
  localparam logic [1:0] REG_LEVEL_THR = 2'd3;

  localparam int unsigned PADDR_W = 4;

  // Error magnitude above which the command is forced to the limit (13 deg)
  localparam logic [16:0] STEEP_ERROR  = 17'd1300;
  // Heading beyond 90 deg flips the error sign
  localparam logic signed [15:0] HEADING_FLIP = 16'sd9000;

  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic signed [15:0] tilt_rate;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] speed_cmd;
    logic               balanced;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_d;
    logic        [14:0] speed_cap;
    logic        [14:0] level_threshold;
  } cfg_t;

  typedef struct packed {
    logic               level;
    logic signed [15:0] speed;
  } law_res_t;

  typedef struct packed {
    action_t action;
    logic    balanced;
  } dwell_res_t;

endpackage

@@ rtl/tbpd_cfg.sv @@
// APB-style register file: gains, speed limit and level threshold.
// Depends on tbpd_pkg for cfg_t and the register indexes.
module tbpd_cfg
  import tbpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_P:    cfg.gain_p          <= pwdata[15:0];
        REG_GAIN_D:    cfg.gain_d          <= pwdata[15:0];
        REG_SPEED_CAP: cfg.speed_cap       <= pwdata[14:0];
        REG_LEVEL_THR: cfg.level_threshold <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:    prdata = {16'd0, cfg.gain_p};
      REG_GAIN_D:    prdata = {16'd0, cfg.gain_d};
      REG_SPEED_CAP: prdata = {17'd0, cfg.speed_cap};
      REG_LEVEL_THR: prdata = {17'd0, cfg.level_threshold};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/tbpd_law.sv @@
// PD control law: signed error, two multiplies, Q8.8 floor shift, steep-error
// override and clamp to the speed limit. Also the level test. Uses tbpd_pkg.
module tbpd_law
  import tbpd_pkg::*;
(
  input  in_item_t item,
  input  cfg_t     cfg,
  output law_res_t res
);

  logic signed [16:0] tilt_ext;
  logic signed [16:0] err;
  logic        [16:0] err_mag;
  logic        [16:0] tilt_mag;
  logic signed [32:0] prod_p;
  logic signed [31:0] prod_d;
  logic signed [33:0] sum;
  logic signed [25:0] shifted;
  logic signed [25:0] lim;
  logic signed [25:0] nlim;
  logic signed [25:0] speed;
  logic               steep;

  assign tilt_ext = {item.tilt_angle[15], item.tilt_angle};
  assign err      = (item.heading > HEADING_FLIP) ? -tilt_ext : tilt_ext;
  assign err_mag  = err[16] ? 17'(-err) : 17'(err);
  assign tilt_mag = tilt_ext[16] ? 17'(-tilt_ext) : 17'(tilt_ext);
  assign steep    = err_mag > STEEP_ERROR;

  assign prod_p  = cfg.gain_p * err;
  assign prod_d  = cfg.gain_d * item.tilt_rate;
  assign sum     = {prod_p[32], prod_p} + {{2{prod_d[31]}}, prod_d};
  // floor(sum / 256): upper bits of the two's complement sum
  assign shifted = sum[33:8];

  assign lim  = {11'd0, cfg.speed_cap};
  assign nlim = -lim;

  always_comb begin
    if (steep) begin
      speed = err[16] ? nlim : lim;
    end else if (shifted > lim) begin
      speed = lim;
    end else if (shifted < nlim) begin
      speed = nlim;
    end else begin
      speed = shifted;
    end
  end

  assign res.speed = speed[15:0];
  assign res.level = tilt_mag < {2'd0, cfg.level_threshold};

endmodule

@@ rtl/tbpd_dwell.sv @@
// Dwell counter and balanced latch: picks drive, hold or lock per beat.
// Uses tbpd_pkg for action_t and dwell_res_t.
module tbpd_dwell
  import tbpd_pkg::*;
#(
  parameter int DWELL_TICKS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       level,
  output dwell_res_t res
);

  logic [2:0] quiet_ticks;
  logic [2:0] quiet_ticks_next;
  logic       balanced_latch;
  logic       balanced_latch_next;

  always_comb begin
    quiet_ticks_next    = quiet_ticks;
    balanced_latch_next = balanced_latch;
    res.action          = ACT_DRIVE;
    if (level) begin
      if (quiet_ticks > 3'(DWELL_TICKS)) begin
        balanced_latch_next = 1'b1;
        res.action          = ACT_LOCK;
      end else begin
        quiet_ticks_next = quiet_ticks + 3'd1;
        res.action       = ACT_HOLD;
      end
    end else begin
      quiet_ticks_next = 3'd0;
    end
    res.balanced = balanced_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_ticks    <= 3'd0;
      balanced_latch <= 1'b0;
    end else if (advance) begin
      quiet_ticks    <= quiet_ticks_next;
      balanced_latch <= balanced_latch_next;
    end
  end

endmodule

@@ rtl/tilt_balance_pd_controller_top.sv @@
// Top level of the tilt balance PD controller.
// Instantiates tbpd_cfg, tbpd_law and tbpd_dwell; types from tbpd_pkg.
//
// Usage:
//   src channel (src_valid/src_stall/src_item) carries one control tick:
//   tilt, tilt rate and heading. res channel (res_valid/res_stall/res_item)
//   returns exactly one beat per tick: action, speed command, balanced flag.
//   Gains, speed limit and level threshold are to be written over the
//   APB-style port only while no tick is in flight; the block does not
//   enforce this. pready is tied high. A taken tick goes to the input
//   register, then its result beat to the result register, with the PD law
//   between. Throughput: one tick per cycle while the receiver does not
//   stall; the two multiplies and the clamp sit in the single stage between
//   the registers. Reset (rst, synchronous) clears both valid flags, the
//   dwell counter, the balanced flag and the configuration registers to
//   zero; src_stall is high during reset. When the receiver stalls, the
//   result beat holds; the input register still takes one more tick, after
//   which src_stall rises until the result beat drains.
module tilt_balance_pd_controller_top
  import tbpd_pkg::*;
#(
  parameter int DWELL_TICKS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  in_item_t           src_item,
  output logic               res_valid,
  input  logic               res_stall,
  output out_item_t          res_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg;
  in_item_t   s1_item;
  logic       s1_valid;
  logic       out_ready;
  logic       move;
  law_res_t   law;
  dwell_res_t dwell;

  tbpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_ready = !res_valid || !res_stall;
  assign src_stall = rst || (s1_valid && !out_ready);
  assign move      = s1_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!src_stall) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      s1_item <= src_item;
    end
  end

  tbpd_law u_law (
    .item (s1_item),
    .cfg  (cfg),
    .res  (law)
  );

  tbpd_dwell #(
    .DWELL_TICKS (DWELL_TICKS)
  ) u_dwell (
    .clk     (clk),
    .rst     (rst),
    .advance (move),
    .level   (law.level),
    .res     (dwell)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= s1_valid;
    end
  end

  // speed is only meaningful when driving
  always_ff @(posedge clk) begin
    if (move) begin
      res_item.action    <= dwell.action;
      res_item.speed_cmd <= (dwell.action == ACT_DRIVE) ? law.speed : 16'sd0;
      res_item.balanced  <= dwell.balanced;
    end
  end

endmodule

@@ rtl/tbpd_checker.sv @@
// Port-level checks for the tilt balance PD controller, bound to the top.
// Uses tbpd_pkg for the item types and action codes.
module tbpd_checker
  import tbpd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      src_stall,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  // a tick is only refused while a result beat is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> res_valid)
    else $error("src_stall without a pending result beat");

  // no drive command accompanies hold or lock
  a_idle_speed_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.action == ACT_HOLD || res_item.action == ACT_LOCK)
      |-> res_item.speed_cmd == 16'sd0)
    else $error("non-zero speed with hold or lock");

  a_lock_sets_balanced: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.action == ACT_LOCK |-> res_item.balanced)
    else $error("lock beat without balanced flag");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result beat changed");

  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind tilt_balance_pd_controller_top tbpd_checker u_tbpd_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

@@ dv/tilt_balance_pd_controller_top_test.sv @@
// Self-checking test of tilt_balance_pd_controller_top: ticks are driven on the
// source channel, results are checked beat by beat against a local PD predictor.
// Depends on tbpd_pkg and the block's RTL only.
module tilt_balance_pd_controller_top_test;
  import tbpd_pkg::*;

  localparam int DWELL       = 4;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               src_valid;
  logic               src_stall;
  in_item_t           src_item;
  logic               res_valid;
  logic               res_stall;
  out_item_t          res_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  tilt_balance_pd_controller_top #(.DWELL_TICKS(DWELL)) uut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the register file and of the dwell state
  logic signed [15:0] kp_shadow;
  logic signed [15:0] kd_shadow;
  logic        [14:0] speed_limit;
  logic        [14:0] level_thr;
  logic        [2:0]  quiet_cnt;
  logic               balanced_seen;

  out_item_t pending_cmds[$];
  int        fails;
  int        idle_cycles;
  bit        idle_on;
  bit        hold_req;

  always #5 clk = ~clk;

  // PD law plus dwell decision for one tick; advances the shadow state
  function automatic out_item_t predict_tick(in_item_t it);
    longint    tilt, rate, err, err_mag, tilt_mag, sum, spd, lim;
    out_item_t r;
    tilt     = longint'(it.tilt_angle);
    rate     = longint'(it.tilt_rate);
    err      = (it.heading > HEADING_FLIP) ? -tilt : tilt;
    err_mag  = (err < 0) ? -err : err;
    tilt_mag = (tilt < 0) ? -tilt : tilt;
    lim      = longint'(speed_limit);
    sum      = longint'(kp_shadow) * err + longint'(kd_shadow) * rate;
    spd      = sum >>> 8;  // floor towards minus infinity
    if (err_mag > longint'(STEEP_ERROR)) spd = (err > 0) ? lim : -lim;
    if (spd > lim) spd = lim;
    if (spd < -lim) spd = -lim;
    if (tilt_mag < longint'(level_thr)) begin
      if (quiet_cnt > DWELL) begin
        balanced_seen = 1'b1;
        r.action      = ACT_LOCK;
      end else begin
        quiet_cnt = quiet_cnt + 3'd1;
        r.action  = ACT_HOLD;
      end
      spd = 0;
    end else begin
      quiet_cnt = '0;
      r.action  = ACT_DRIVE;
    end
    r.speed_cmd = spd[15:0];
    r.balanced  = balanced_seen;
    return r;
  endfunction

  function automatic in_item_t make_tick(int tilt, int rate, int head);
    in_item_t it;
    it.tilt_angle = tilt[15:0];
    it.tilt_rate  = rate[15:0];
    it.heading    = head[15:0];
    return it;
  endfunction

  // Sends one tick, with random gaps; the expectation is queued on acceptance
  task automatic send_tick(in_item_t it);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      src_valid = 1'b0;
      @(negedge clk);
    end
    src_valid = 1'b1;
    src_item  = it;
    do @(posedge clk); while (src_stall);
    pending_cmds.push_back(predict_tick(it));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    src_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_P:    kp_shadow   = val[15:0];
      REG_GAIN_D:    kd_shadow   = val[15:0];
      REG_SPEED_CAP: speed_limit = val[14:0];
      REG_LEVEL_THR: level_thr   = val[14:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(logic [15:0] gp, logic [15:0] gd, logic [14:0] ms,
                            logic [14:0] thr);
    wait_drained();
    apb_write(REG_GAIN_P, {16'h0, gp});
    apb_write(REG_GAIN_D, {16'h0, gd});
    apb_write(REG_SPEED_CAP, {17'h0, ms});
    apb_write(REG_LEVEL_THR, {17'h0, thr});
  endtask

  function automatic int rand_rate();
    if ($urandom_range(0, 1)) return int'($urandom_range(0, 65535));
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  function automatic int rand_heading();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return int'($urandom_range(0, 36000)) - 18000;
    if (pick < 9) return int'($urandom_range(8998, 9003));
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic in_item_t level_tick();
    int thr;
    thr = int'(level_thr);
    return make_tick(int'($urandom_range(0, 2 * thr - 2)) - (thr - 1), rand_rate(),
                     rand_heading());
  endfunction

  function automatic in_item_t drive_tick();
    int thr, mag;
    thr = int'(level_thr);
    case ($urandom_range(0, 19))
      0:       mag = 32768;
      1, 2:    mag = (thr > 1302) ? thr : int'($urandom_range(1298, 1302));
      default: mag = thr + int'($urandom_range(0, 18000 - thr));
    endcase
    if (mag < thr) mag = thr;
    return make_tick($urandom_range(0, 1) ? mag : -mag, rand_rate(), rand_heading());
  endfunction

  function automatic in_item_t noise_tick();
    return make_tick(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 65535)));
  endfunction

  task automatic random_config();
    logic [15:0] gp, gd;
    logic [14:0] ms, thr;
    case ($urandom_range(0, 9))
      0:       gp = 16'h8000;
      1:       gp = 16'h7fff;
      2, 3:    gp = 16'($urandom());
      default: gp = 16'($urandom_range(0, 2048) - 1024);
    endcase
    case ($urandom_range(0, 9))
      0:       gd = 16'h8000;
      1:       gd = 16'h7fff;
      2, 3:    gd = 16'($urandom());
      default: gd = 16'($urandom_range(0, 1024) - 512);
    endcase
    case ($urandom_range(0, 9))
      0:       ms = 15'd0;
      1:       ms = 15'd32767;
      default: ms = 15'($urandom_range(0, 32767));
    endcase
    case ($urandom_range(0, 9))
      0:       thr = 15'd0;
      1:       thr = 15'd18000;
      2:       thr = 15'($urandom_range(0, 18000));
      default: thr = 15'($urandom_range(1, 3000));
    endcase
    set_config(gp, gd, ms, thr);
  endtask

  // Runs of level ticks followed by a few drive ticks, with some noise
  task automatic random_ticks(int count);
    int sent, run, burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 2) begin
        send_tick(noise_tick());
        sent++;
      end else begin
        run   = (level_thr > 0) ? $urandom_range(0, 9) : 0;
        burst = $urandom_range(1, 3);
        repeat (run) send_tick(level_tick());
        repeat (burst) send_tick(drive_tick());
        sent += run + burst;
      end
    end
  endtask

  task automatic test_reset_defaults();
    // all registers zero: never level, every command clamped to zero
    send_tick(make_tick(1000, 32767, 0));
    send_tick(make_tick(-32768, -32768, 18000));
  endtask

  task automatic test_field_extremes();
    set_config(16'h8000, 16'h7fff, 15'd32767, 15'd0);
    send_tick(make_tick(1300, 32767, 0));
    send_tick(make_tick(1301, -32768, 0));
    send_tick(make_tick(-1301, 32767, 0));
    send_tick(make_tick(-32768, 0, 9001));
    send_tick(make_tick(32767, -1, 9000));
    send_tick(make_tick(-18000, -32768, 18000));
    send_tick(make_tick(18000, 32767, -18000));
    send_tick(make_tick(0, -32768, 9001));
    set_config(16'h7fff, 16'h8000, 15'd0, 15'd18000);
    send_tick(make_tick(17999, 32767, 0));
    send_tick(make_tick(-18000, -32768, 9001));
  endtask

  task automatic test_dwell_lock();
    set_config(16'sd256, 16'sd0, 15'd1000, 15'd500);
    repeat (6) send_tick(make_tick(499, 100, 0));   // count up, then lock
    send_tick(make_tick(-499, -100, 9001));          // stays locked
    send_tick(make_tick(500, 0, 0));                 // threshold itself drives
    send_tick(make_tick(0, 0, 0));                   // latch survives
  endtask

  task automatic test_receiver_holdoff();
    random_config();
    send_tick(drive_tick());
    hold_req = 1'b1;
    random_ticks(20);
  endtask

  task automatic test_sender_pause();
    random_ticks(15);
    wait_drained();
    random_ticks(15);
  endtask

  task automatic test_no_idle_stretch();
    random_config();
    idle_on = 1'b0;
    random_ticks(80);
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    repeat (6) begin
      random_config();
      random_ticks(95);
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req  = 1'b0;
        res_stall = 1'b0;
      end else begin
        res_stall = idle_on && ($urandom_range(0, 99) < 25);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want, got;
    if (!rst && res_valid && !res_stall) begin
      got = res_item;
      if (pending_cmds.size() == 0) begin
        $error("result beat with nothing expected: action=%0d speed_cmd=%0d",
               got.action, got.speed_cmd);
        fails++;
      end else begin
        want = pending_cmds.pop_front();
        if (got.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, got.action);
          fails++;
        end
        if (got.speed_cmd !== want.speed_cmd) begin
          $error("speed_cmd: expected %0d, got %0d", want.speed_cmd, got.speed_cmd);
          fails++;
        end
        if (got.balanced !== want.balanced) begin
          $error("balanced: expected %0d, got %0d", want.balanced, got.balanced);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tilt_balance_pd_controller_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    src_valid     = 1'b0;
    src_item      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    kp_shadow     = '0;
    kd_shadow     = '0;
    speed_limit   = '0;
    level_thr     = '0;
    quiet_cnt     = '0;
    balanced_seen = 1'b0;
    fails         = 0;
    idle_cycles   = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_dwell_lock();
    test_receiver_holdoff();
    test_sender_pause();
    test_no_idle_stretch();
    test_random_phases();

    wait_drained();
    if (pending_cmds.size() != 0) begin
      $error("%0d expected results never arrived", pending_cmds.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tilt_balance_pd_controller_top: match");
    end else begin
      $display("tilt_balance_pd_controller_top: mismatch");
    end
    $finish;
  end

endmodule
